### design/pftoa_pkg.sv
// Shared types and constants for the pixel format to ARGB8888 converter.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package pftoa_pkg;

	// pixel_format codes
	localparam logic [2:0] FMT_RGB555   = 3'd0;
	localparam logic [2:0] FMT_RGB565   = 3'd1;
	localparam logic [2:0] FMT_ARGB4444 = 3'd2;
	localparam logic [2:0] FMT_BGR888   = 3'd3;
	localparam logic [2:0] FMT_BGRX888  = 3'd4;
	localparam logic [2:0] FMT_BGRA8888 = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;
	localparam logic [1:0] REG_ROW_STRIDE   = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int FMT_W       = 3;
	localparam int DIM_W       = 13;
	localparam int STRIDE_W    = 15;

	// reset values of the registers
	localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT = FMT_BGRA8888;
	localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd1;
	localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd1;
	localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 15'd4;

	// floor(v*255/31) = (v*EXP5_MUL) >> EXP_SHIFT for v in 0..31, likewise /63
	localparam logic [25:0] EXP5_MUL  = 26'd34501755;
	localparam logic [24:0] EXP6_MUL  = 25'd16977135;
	localparam int          EXP_SHIFT = 22;

	localparam int QUEUE_DEPTH = 2;

	// one classified transaction handed from the front to the back
	typedef struct packed {
		logic [31:0]      raw;
		logic [FMT_W-1:0] fmt;
		logic             last;
		logic             err;
	} pftoa_item_t;

endpackage

### design/pixel_format_to_argb8888.sv
// Converts a raw byte stream of RGB555/RGB565/ARGB4444/BGR888/BGRX888/BGRA8888 pixels into
// one ARGB8888 word per pixel, skipping row padding and marking the final pixel with tlast;
// a bad configuration returns a zero word with tuser set for every byte. One byte is taken
// per clock on s_axis while the two-entry queue between the counting front end and the
// converting back end has room; a full queue, caused only by m_axis_tready held low, stalls
// s_axis. A pixel is queued at the edge that accepts its last byte and moves into the output
// register when the back end pops it, which needs an empty output register or m_axis_tready high.
// Register writes restart the stream and must only be issued while the block is idle.
`timescale 1ns / 1ps

module pixel_format_to_argb8888 #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pftoa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pftoa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,  // [31:0] pixel_argb
	output logic                              m_axis_tlast,  // end_of_image
	output logic [0:0]                        m_axis_tuser   // [0] config_error
);

	logic                   push;
	pftoa_pkg::pftoa_item_t push_item;
	logic                   queue_full;
	logic                   pop;
	logic                   queue_not_empty;
	pftoa_pkg::pftoa_item_t pop_item;
	logic                   out_err;

	pftoa_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	pftoa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.pop_item  (pop_item)
	);

	pftoa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queue_not_empty),
		.item       (pop_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pixel  (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_err    (out_err)
	);

	assign m_axis_tuser = out_err;

endmodule

### design/pftoa_front.sv
// Front end: configuration registers, byte/row/image counters and pixel assembly.
// Emits one pftoa_pkg::pftoa_item_t per completed pixel or per byte under bad config.
`timescale 1ns / 1ps

module pftoa_front #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pftoa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pftoa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          in_byte,
	output logic                                push,
	output pftoa_pkg::pftoa_item_t              push_item,
	input  logic                                queue_full
);

	localparam int RW = $clog2(MAX_DIMENSION);
	localparam int CW = ((RW > pftoa_pkg::DIM_W) ? RW : pftoa_pkg::DIM_W) + 1;

	logic [pftoa_pkg::FMT_W-1:0]    fmt_q;
	logic [pftoa_pkg::DIM_W-1:0]    width_q;
	logic [pftoa_pkg::DIM_W-1:0]    height_q;
	logic [pftoa_pkg::STRIDE_W-1:0] stride_q;

	logic [1:0]    byte_in_pixel_q;
	logic [23:0]   partial_q;
	logic [14:0]   byte_in_row_q;
	logic [RW-1:0] row_index_q;

	logic [2:0]  bpp;
	logic [15:0] row_data;
	logic        cfg_bad;
	logic        accept;
	logic        in_data;
	logic        pixel_done;
	logic [15:0] row_next;
	logic        row_end;
	logic        last_row;
	logic [4:0]  final_shift;
	logic [4:0]  part_shift;
	logic [31:0] raw;
	logic [31:0] part_new;

	always_comb begin
		case (fmt_q)
			pftoa_pkg::FMT_RGB555,
			pftoa_pkg::FMT_RGB565,
			pftoa_pkg::FMT_ARGB4444: bpp = 3'd2;
			pftoa_pkg::FMT_BGR888:   bpp = 3'd3;
			pftoa_pkg::FMT_BGRX888,
			pftoa_pkg::FMT_BGRA8888: bpp = 3'd4;
			default:                 bpp = 3'd0;
		endcase
	end

	always_comb begin
		case (bpp)
			3'd2:    row_data = {2'b00, width_q, 1'b0};
			3'd3:    row_data = {2'b00, width_q, 1'b0} + {3'b000, width_q};
			3'd4:    row_data = {1'b0, width_q, 2'b00};
			default: row_data = '0;
		endcase
	end

	assign cfg_bad = (bpp == 3'd0) || (width_q == '0) || (height_q == '0) ||
		(32'(width_q) > 32'(MAX_DIMENSION)) || (32'(height_q) > 32'(MAX_DIMENSION)) ||
		({1'b0, stride_q} < row_data);

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign in_data    = {1'b0, byte_in_row_q} < row_data;
	assign pixel_done = in_data && (({1'b0, byte_in_pixel_q} + 3'd1) >= bpp);
	assign row_next   = {1'b0, byte_in_row_q} + 16'd1;
	assign row_end    = row_next >= {1'b0, stride_q};
	assign last_row   = (CW'(row_index_q) + CW'(1)) >= CW'(height_q);

	assign final_shift = {bpp[1:0] - 2'd1, 3'b000};
	assign part_shift  = {byte_in_pixel_q, 3'b000};
	assign raw         = {8'h00, partial_q} | ({24'h000000, in_byte} << final_shift);
	assign part_new    = {8'h00, partial_q} | ({24'h000000, in_byte} << part_shift);

	assign push = accept && (cfg_bad || pixel_done);

	always_comb begin
		push_item.fmt  = fmt_q;
		push_item.err  = cfg_bad;
		push_item.raw  = raw;
		push_item.last = (row_next >= row_data) && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= pftoa_pkg::RST_PIXEL_FORMAT;
			width_q  <= pftoa_pkg::RST_IMAGE_WIDTH;
			height_q <= pftoa_pkg::RST_IMAGE_HEIGHT;
			stride_q <= pftoa_pkg::RST_ROW_STRIDE;
		end else if (cfg_we) begin
			case (cfg_index)
				pftoa_pkg::REG_PIXEL_FORMAT: fmt_q    <= cfg_data[pftoa_pkg::FMT_W-1:0];
				pftoa_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[pftoa_pkg::DIM_W-1:0];
				pftoa_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[pftoa_pkg::DIM_W-1:0];
				pftoa_pkg::REG_ROW_STRIDE:   stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_pixel_q <= '0;
			partial_q       <= '0;
			byte_in_row_q   <= '0;
			row_index_q     <= '0;
		end else if (cfg_we) begin
			// any register write restarts the stream
			byte_in_pixel_q <= '0;
			partial_q       <= '0;
			byte_in_row_q   <= '0;
			row_index_q     <= '0;
		end else if (accept && !cfg_bad) begin
			if (row_end) begin
				byte_in_pixel_q <= '0;
				partial_q       <= '0;
				byte_in_row_q   <= '0;
				row_index_q     <= last_row ? '0 : row_index_q + RW'(1);
			end else begin
				byte_in_row_q <= row_next[14:0];
				if (pixel_done) begin
					byte_in_pixel_q <= '0;
					partial_q       <= '0;
				end else if (in_data) begin
					byte_in_pixel_q <= byte_in_pixel_q + 2'd1;
					partial_q       <= part_new[23:0];
				end
			end
		end
	end

endmodule

### design/pftoa_queue.sv
// Short queue between the front and back ends of the converter.
// Holds pftoa_pkg::pftoa_item_t entries; depth from pftoa_pkg::QUEUE_DEPTH.
`timescale 1ns / 1ps

module pftoa_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pftoa_pkg::pftoa_item_t push_item,
	output logic                   full,
	input  logic                   pop,
	output logic                   not_empty,
	output pftoa_pkg::pftoa_item_t pop_item
);

	localparam int AW = $clog2(pftoa_pkg::QUEUE_DEPTH);

	pftoa_pkg::pftoa_item_t mem_q [pftoa_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full      = count_q == (AW+1)'(pftoa_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == pftoa_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == pftoa_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/pftoa_back.sv
// Back end: channel expansion of a queued pixel into ARGB8888 and the output register.
// Depends on pftoa_pkg for the item type, format codes and expansion constants.
`timescale 1ns / 1ps

module pftoa_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  pftoa_pkg::pftoa_item_t item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            out_pixel,
	output logic                   out_last,
	output logic                   out_err
);

	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [30:0] p;
		p = 31'(v) * 31'(pftoa_pkg::EXP5_MUL);
		return p[pftoa_pkg::EXP_SHIFT+7:pftoa_pkg::EXP_SHIFT];
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [30:0] p;
		p = 31'(v) * 31'(pftoa_pkg::EXP6_MUL);
		return p[pftoa_pkg::EXP_SHIFT+7:pftoa_pkg::EXP_SHIFT];
	endfunction

	logic        valid_q;
	logic [31:0] pixel_q;
	logic        last_q;
	logic        err_q;
	logic [15:0] w;
	logic [7:0]  a, r, g, b;

	assign w = item.raw[15:0];

	always_comb begin
		a = 8'hFF;
		r = item.raw[23:16];
		g = item.raw[15:8];
		b = item.raw[7:0];
		case (item.fmt)
			pftoa_pkg::FMT_RGB555: begin
				r = expand5(w[14:10]);
				g = expand5(w[9:5]);
				b = expand5(w[4:0]);
			end
			pftoa_pkg::FMT_RGB565: begin
				r = expand5(w[15:11]);
				g = expand6(w[10:5]);
				b = expand5(w[4:0]);
			end
			pftoa_pkg::FMT_ARGB4444: begin
				// times 17 is nibble replication
				a = {w[15:12], w[15:12]};
				r = {w[11:8], w[11:8]};
				g = {w[7:4], w[7:4]};
				b = {w[3:0], w[3:0]};
			end
			pftoa_pkg::FMT_BGR888,
			pftoa_pkg::FMT_BGRX888: ;
			default: a = item.raw[31:24];
		endcase
	end

	assign pop       = item_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_pixel = pixel_q;
	assign out_last  = last_q;
	assign out_err   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q <= item.err ? 32'h0 : {a, r, g, b};
			last_q  <= item.err ? 1'b0 : item.last;
			err_q   <= item.err;
		end
	end

endmodule
